// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/lfac_pkg.sv -----
// shared constants and types for the lru cache directory
package lfac_pkg;

    // field widths fixed by the interface
    localparam int BLOCK_W      = 32;
    localparam int COUNT_W      = 32;
    localparam int LINE_IDX_W   = 4;
    localparam int LINES_W      = 5;
    localparam int OUT_DATA_W   = 104;
    localparam int OUT_USER_W   = 2;

    // defaults for the top level parameters
    localparam int DEF_MAX_LINES = 16;
    localparam int DEF_AGE_BITS  = 16;

    // reset value of the lines-in-use register
    localparam logic [LINES_W-1:0] LINES_RESET = 5'd16;

    // positions in the output tuser
    localparam int USER_HIT_BIT   = 0;
    localparam int USER_EVICT_BIT = 1;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/lfac_cell.sv -----
// one directory line: tag, valid and age, plus one registered stage of the search chain
module lfac_cell
    import lfac_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES,
    parameter int AGE_BITS  = DEF_AGE_BITS,
    parameter int IDX       = 0,
    localparam int IW       = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1,
    localparam int CARRY_W  = 2 + 3 * IW + AGE_BITS + BLOCK_W,
    localparam int UPD_W    = 3 + IW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_use,
    input  logic [BLOCK_W-1:0] i_block,
    input  logic [CARRY_W-1:0] i_carry,
    input  logic [UPD_W-1:0]   i_upd,
    output logic [CARRY_W-1:0] o_carry
);

    // search state handed from cell to cell
    typedef struct packed {
        logic                hit_found;
        logic [IW-1:0]       hit_idx;
        logic                inv_found;
        logic [IW-1:0]       inv_idx;
        logic [AGE_BITS-1:0] best_age;
        logic [IW-1:0]       best_idx;
        logic [BLOCK_W-1:0]  best_tag;
    } t_carry;

    // update broadcast from the sequencer
    typedef struct packed {
        logic          en;
        logic          clear;
        logic          miss;
        logic [IW-1:0] touched;
    } t_upd;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_carry              w_cin;
    t_carry              n_carry;
    t_carry              r_carry;
    t_upd                w_upd;
    logic [BLOCK_W-1:0]  r_tag;
    logic [BLOCK_W-1:0]  n_tag;
    logic                r_valid;
    logic                n_valid;
    logic [AGE_BITS-1:0] r_age;
    logic [AGE_BITS-1:0] n_age;

    assign w_cin   = t_carry'(i_carry);
    assign w_upd   = t_upd'(i_upd);
    assign o_carry = CARRY_W'(r_carry);

    // search step: first hit, first invalid line, oldest line
    always_comb begin
        n_carry = w_cin;
        if (i_in_use) begin
            if (r_valid && (r_tag == i_block) && !w_cin.hit_found) begin
                n_carry.hit_found = 1'b1;
                n_carry.hit_idx   = MY_IDX;
            end
            if (!r_valid && !w_cin.inv_found) begin
                n_carry.inv_found = 1'b1;
                n_carry.inv_idx   = MY_IDX;
            end
            // line 0 always opens the age search, strict compare keeps the lowest index
            if ((IDX == 0) || (r_age > w_cin.best_age)) begin
                n_carry.best_age = r_age;
                n_carry.best_idx = MY_IDX;
                n_carry.best_tag = r_tag;
            end
        end
    end

    // line update after the access
    always_comb begin
        n_tag   = r_tag;
        n_valid = r_valid;
        n_age   = r_age;
        if (w_upd.en) begin
            if (i_in_use) begin
                if (w_upd.touched == MY_IDX) begin
                    n_valid = 1'b1;
                    n_age   = '0;
                    if (w_upd.miss) begin
                        n_tag = i_block;
                    end
                end else if (!r_valid) begin
                    n_age = '0;
                end else if (r_age != {AGE_BITS{1'b1}}) begin
                    n_age = r_age + AGE_BITS'(1);
                end
            end
            // end of run drops every line
            if (w_upd.clear) begin
                n_valid = 1'b0;
                n_age   = '0;
            end
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
    end

    // tag and chain stage carry no reset
    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_carry <= n_carry;
    end

endmodule

// ----- rtl/core/lru_fully_assoc_cache_policy.sv -----
// top level: fully associative lru cache directory built from a chain of line cells
//
//  channel   dir  transfer when                 payload
//  s_axis    in   s_axis_tvalid & tready        tdata block_id, tlast end_of_run
//  m_axis    out  m_axis_tvalid & tready        tdata index/evicted/totals, tuser flags
//  cfg       in   i_cfg_wr_en                   i_cfg_wr_data lines_in_use
//
// the search for an access walks the cell chain one cell a cycle,
// then the done state updates all lines and loads the output register.
// the next access is taken while a result waits; a stalled result holds the update back.
// reset is synchronous: lines invalid, ages and totals zero, lines_in_use back to 16.
module lru_fully_assoc_cache_policy
    import lfac_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES,
    parameter int AGE_BITS  = DEF_AGE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [LINES_W-1:0]    i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BLOCK_W-1:0]    s_axis_tdata,   // block_id
    input  logic                  s_axis_tlast,   // end_of_run
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // line_index, evicted_block, hit_total,
                                                  // miss_total, zero pad
    output logic [OUT_USER_W-1:0] m_axis_tuser    // hit, evicted_valid
);

    localparam int IW      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int NW      = ($clog2(MAX_LINES + 1) > LINES_W) ? $clog2(MAX_LINES + 1) : LINES_W;
    localparam int CARRY_W = 2 + 3 * IW + AGE_BITS + BLOCK_W;
    localparam int UPD_W   = 3 + IW;
    localparam int PAD_W   = OUT_DATA_W - LINE_IDX_W - BLOCK_W - 2 * COUNT_W;

    typedef struct packed {
        logic                hit_found;
        logic [IW-1:0]       hit_idx;
        logic                inv_found;
        logic [IW-1:0]       inv_idx;
        logic [AGE_BITS-1:0] best_age;
        logic [IW-1:0]       best_idx;
        logic [BLOCK_W-1:0]  best_tag;
    } t_carry;

    typedef struct packed {
        logic          en;
        logic          clear;
        logic          miss;
        logic [IW-1:0] touched;
    } t_upd;

    t_state              r_state;
    t_state              n_state;
    logic [IW-1:0]       r_cnt;
    logic [IW-1:0]       n_cnt;
    logic [LINES_W-1:0]  r_lines;
    logic [BLOCK_W-1:0]  r_block;
    logic                r_last;
    logic [COUNT_W-1:0]  r_hit_cnt;
    logic [COUNT_W-1:0]  r_miss_cnt;
    logic [COUNT_W-1:0]  n_hit_cnt;
    logic [COUNT_W-1:0]  n_miss_cnt;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic                w_in_xfer;
    logic                w_fire;
    logic [NW-1:0]       w_lines;
    logic [NW-1:0]       w_n_eff;
    logic [MAX_LINES-1:0] w_in_use;
    logic [CARRY_W-1:0]  w_chain [MAX_LINES];
    t_carry              w_res;
    t_upd                w_upd;
    logic                w_hit;
    logic                w_ev_valid;
    logic [BLOCK_W-1:0]  w_ev_block;
    logic [IW-1:0]       w_touched;
    logic [31:0]         w_touched_ext;

    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_fire        = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // effective line count: zero acts as one, clipped to the cell count
    always_comb begin
        w_lines = NW'(r_lines);
        if (w_lines == '0) begin
            w_n_eff = NW'(1);
        end else if (w_lines > NW'(MAX_LINES)) begin
            w_n_eff = NW'(MAX_LINES);
        end else begin
            w_n_eff = w_lines;
        end
    end

    // chain of line cells
    for (genvar k = 0; k < MAX_LINES; k++) begin : g_cell
        logic [CARRY_W-1:0] w_cin;
        assign w_in_use[k] = (NW'(k) < w_n_eff);
        if (k == 0) begin : g_head
            assign w_cin = '0;
        end else begin : g_link
            assign w_cin = w_chain[k-1];
        end
        lfac_cell #(
            .MAX_LINES (MAX_LINES),
            .AGE_BITS  (AGE_BITS),
            .IDX       (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_in_use (w_in_use[k]),
            .i_block  (r_block),
            .i_carry  (w_cin),
            .i_upd    (UPD_W'(w_upd)),
            .o_carry  (w_chain[k])
        );
    end

    // result of the search at the tail of the chain
    always_comb begin
        w_res      = t_carry'(w_chain[MAX_LINES-1]);
        w_hit      = w_res.hit_found;
        w_ev_valid = !w_res.hit_found && !w_res.inv_found;
        w_ev_block = w_ev_valid ? w_res.best_tag : '0;
        if (w_res.hit_found) begin
            w_touched = w_res.hit_idx;
        end else if (w_res.inv_found) begin
            w_touched = w_res.inv_idx;
        end else begin
            w_touched = w_res.best_idx;
        end
        w_touched_ext = 32'(w_touched);
    end

    // saturating totals including this access
    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (w_hit) begin
            if (r_hit_cnt != {COUNT_W{1'b1}}) begin
                n_hit_cnt = r_hit_cnt + COUNT_W'(1);
            end
        end else if (r_miss_cnt != {COUNT_W{1'b1}}) begin
            n_miss_cnt = r_miss_cnt + COUNT_W'(1);
        end
    end

    // update broadcast to the cells
    always_comb begin
        w_upd.en      = w_fire;
        w_upd.clear   = r_last;
        w_upd.miss    = !w_hit;
        w_upd.touched = w_touched;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_in_xfer) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == IW'(MAX_LINES - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_lines     <= LINES_RESET;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_lines <= i_cfg_wr_data;
            end
            if (w_fire) begin
                r_hit_cnt   <= r_last ? '0 : n_hit_cnt;
                r_miss_cnt  <= r_last ? '0 : n_miss_cnt;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input and output payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_block <= s_axis_tdata;
            r_last  <= s_axis_tlast;
        end
        if (w_fire) begin
            r_out_data <= {{PAD_W{1'b0}}, n_miss_cnt, n_hit_cnt, w_ev_block,
                           w_touched_ext[LINE_IDX_W-1:0]};
            r_out_user <= {w_ev_valid, w_hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/core/lfac_chk.sv -----
// port-level checker for the lru cache directory, bound to the top level
`include "assert_macros.svh"

module lfac_chk
    import lfac_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic [LINES_W-1:0]    i_cfg_wr_data,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [BLOCK_W-1:0]    s_axis_tdata,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one access at a time: no transfer right after an input transfer
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a hit never evicts
    `ASSERT_IMPLY(a_hit_no_evict, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[USER_HIT_BIT] && m_axis_tuser[USER_EVICT_BIT]))

    // no eviction means the evicted block reads zero
    `ASSERT_IMPLY(a_evict_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[USER_EVICT_BIT], m_axis_tdata[35:4] == '0)

endmodule

bind lru_fully_assoc_cache_policy lfac_chk u_lfac_chk (.*);

// ----- bench/tb_top.sv -----
// self-checking bench for the lru cache directory: directed cases, then random access streams
`timescale 1ns / 100ps

module tb_top;
    import lfac_pkg::*;

    localparam int N_LINES     = DEF_MAX_LINES;
    localparam int AGE_W       = DEF_AGE_BITS;
    localparam int STALL_LIMIT = 4000;

    // one lookup result, as carried on the output stream
    typedef struct packed {
        logic                  hit;
        logic [LINE_IDX_W-1:0] line;
        logic                  evicted;
        logic [BLOCK_W-1:0]    evicted_block;
        logic [COUNT_W-1:0]    hits;
        logic [COUNT_W-1:0]    misses;
    } t_lookup;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [LINES_W-1:0]    i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BLOCK_W-1:0]    s_axis_tdata;   // block_id
    logic                  s_axis_tlast;   // end_of_run
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // line_index, evicted_block, hit_total,
                                           // miss_total, zero pad
    logic [OUT_USER_W-1:0] m_axis_tuser;   // hit, evicted_valid

    // shadow copy of the directory
    logic [LINES_W-1:0] dir_lines;
    logic [BLOCK_W-1:0] dir_tag   [N_LINES];
    bit                 dir_valid [N_LINES];
    bit   [AGE_W-1:0]   dir_age   [N_LINES];
    logic [COUNT_W-1:0] dir_hits;
    logic [COUNT_W-1:0] dir_misses;

    t_lookup        pending_lookups[$];
    int             error_count;
    int             quiet_cycles;
    int             ready_hold;
    bit             gaps_enabled;
    logic [BLOCK_W-1:0] id_pool[$];

    lru_fully_assoc_cache_policy dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // clear the run state: valid bits, ages and totals
    function automatic void clear_directory();
        for (int k = 0; k < N_LINES; k++) begin
            dir_valid[k] = 1'b0;
            dir_age[k]   = '0;
        end
        dir_hits   = '0;
        dir_misses = '0;
    endfunction

    // expected result of one access, updating the shadow directory
    function automatic t_lookup predict_access(input logic [BLOCK_W-1:0] blk,
                                               input logic last_acc);
        t_lookup r;
        int      n;
        int      touched;
        bit      found;
        n = (dir_lines == 0) ? 1 : ((dir_lines > N_LINES) ? N_LINES : int'(dir_lines));
        touched = 0;
        found   = 1'b0;
        r       = '0;
        // lowest matching valid line wins
        for (int k = 0; k < n; k++) begin
            if (!found && dir_valid[k] && dir_tag[k] == blk) begin
                touched = k;
                found   = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (dir_hits != '1)
                dir_hits++;
        end else begin
            // fill the first invalid line, else replace the oldest
            for (int k = 0; k < n; k++) begin
                if (!found && !dir_valid[k]) begin
                    touched = k;
                    found   = 1'b1;
                end
            end
            if (!found) begin
                touched = 0;
                for (int k = 1; k < n; k++)
                    if (dir_age[k] > dir_age[touched])
                        touched = k;
                r.evicted       = 1'b1;
                r.evicted_block = dir_tag[touched];
            end
            dir_tag[touched]   = blk;
            dir_valid[touched] = 1'b1;
            if (dir_misses != '1)
                dir_misses++;
        end
        // age every line in use except the touched one
        for (int k = 0; k < n; k++) begin
            if (!dir_valid[k] || k == touched)
                dir_age[k] = '0;
            else if (dir_age[k] != '1)
                dir_age[k]++;
        end
        r.line   = touched[LINE_IDX_W-1:0];
        r.hits   = dir_hits;
        r.misses = dir_misses;
        if (last_acc)
            clear_directory();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // one access transfer on the input stream
    task automatic send_access(input logic [BLOCK_W-1:0] blk, input logic last_acc);
        int gap;
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tlast  <= last_acc;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_lookups.push_back(predict_access(blk, last_acc));
    endtask

    // hold off until every result is back and the pipeline is empty
    task automatic drain_lookups();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (N_LINES + 4) @(posedge i_clk);
    endtask

    task automatic set_line_count(input logic [LINES_W-1:0] count);
        drain_lookups();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        dir_lines = count;
    endtask

    // default line count after reset, extreme block numbers
    task automatic test_reset_count();
        send_access(32'h0000_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'h0000_0000, 1'b0);
    endtask

    // fills, a hit and replacements of the least recently used line
    task automatic test_fill_and_evict();
        set_line_count(5'd4);
        send_access(32'h5555_5555, 1'b0);
        send_access(32'hAAAA_AAAA, 1'b0);
        send_access(32'h1234_5678, 1'b0);
        send_access(32'h5555_5555, 1'b0);
        send_access(32'h8000_0001, 1'b0);
        send_access(32'h7FFF_FFFE, 1'b0);
    endtask

    // count zero acts as one line, counts above the line total act as all lines
    task automatic test_count_extremes();
        set_line_count(5'd0);
        send_access(32'hDEAD_BEEF, 1'b0);
        send_access(32'hDEAD_BEEF, 1'b0);
        send_access(32'h0BAD_F00D, 1'b0);
        set_line_count(5'd31);
        send_access(32'h0BAD_F00D, 1'b0);
        send_access(32'hAAAA_AAAA, 1'b0);
        set_line_count(5'd17);
        send_access(32'h1234_5678, 1'b0);
    endtask

    // same block held twice after a shrink and regrow: lowest line is the hit
    task automatic test_duplicate_lines();
        set_line_count(5'd2);
        send_access(32'h0000_0A0A, 1'b1);
        send_access(32'h0000_0A0A, 1'b0);
        send_access(32'h0000_0B0B, 1'b0);
        set_line_count(5'd1);
        send_access(32'h0000_0B0B, 1'b0);
        set_line_count(5'd2);
        send_access(32'h0000_0B0B, 1'b0);
    endtask

    // end of run clears lines and totals once its result is out
    task automatic test_end_of_run();
        send_access(32'h0000_0B0B, 1'b1);
        send_access(32'h0000_0B0B, 1'b0);
        send_access(32'h0000_0A0A, 1'b0);
    endtask

    // bursts of accesses over a small pool of blocks, mostly with a new line count per burst
    task automatic run_bursts(input int total);
        int sent;
        int burst_len;
        int pool_size;
        int n_eff;
        logic [LINES_W-1:0] count;
        logic [BLOCK_W-1:0] blk;
        sent = 0;
        while (sent < total) begin
            case ($urandom_range(0, 9))
                0: count = 5'd0;
                1: count = 5'd1;
                2: count = 5'd16;
                3: count = 5'd17;
                4: count = 5'd31;
                5: count = 5'($urandom_range(0, 31));
                default: count = 5'($urandom_range(2, 8));
            endcase
            // skip the write now and then so runs carry over line counts
            if ($urandom_range(0, 3) != 0)
                set_line_count(count);
            n_eff = (dir_lines == 0) ? 1 : ((dir_lines > N_LINES) ? N_LINES : int'(dir_lines));
            pool_size = $urandom_range(1, 2 * n_eff + 2);
            id_pool.delete();
            for (int k = 0; k < pool_size; k++) begin
                case ($urandom_range(0, 7))
                    0: id_pool.push_back(32'h0000_0000);
                    1: id_pool.push_back(32'hFFFF_FFFF);
                    2: id_pool.push_back(32'($urandom_range(0, 15)));
                    default: id_pool.push_back($urandom);
                endcase
            end
            burst_len = $urandom_range(20, 80);
            for (int k = 0; k < burst_len && sent < total; k++) begin
                if ($urandom_range(0, 9) == 0)
                    blk = $urandom;
                else
                    blk = id_pool[$urandom_range(0, pool_size - 1)];
                send_access(blk, ($urandom_range(0, 49) == 0));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        gaps_enabled = 1'b1;
        run_bursts(800);
    endtask

    task automatic test_steady_stream();
        gaps_enabled = 1'b0;
        run_bursts(150);
    endtask

    // output side: random stall bursts while gaps are enabled
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(1, 15) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_lookup
        t_lookup want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(m_axis_tdata), 64'd0);
            end else begin
                want = pending_lookups.pop_front();
                if (m_axis_tuser[USER_HIT_BIT] !== want.hit)
                    report_mismatch("hit", 64'(m_axis_tuser[USER_HIT_BIT]), 64'(want.hit));
                if (m_axis_tuser[USER_EVICT_BIT] !== want.evicted)
                    report_mismatch("evicted_valid", 64'(m_axis_tuser[USER_EVICT_BIT]),
                                    64'(want.evicted));
                if (m_axis_tdata[3:0] !== want.line)
                    report_mismatch("line_index", 64'(m_axis_tdata[3:0]), 64'(want.line));
                if (m_axis_tdata[35:4] !== want.evicted_block)
                    report_mismatch("evicted_block", 64'(m_axis_tdata[35:4]),
                                    64'(want.evicted_block));
                if (m_axis_tdata[67:36] !== want.hits)
                    report_mismatch("hit_total", 64'(m_axis_tdata[67:36]), 64'(want.hits));
                if (m_axis_tdata[99:68] !== want.misses)
                    report_mismatch("miss_total", 64'(m_axis_tdata[99:68]), 64'(want.misses));
                if (m_axis_tdata[103:100] !== 4'd0)
                    report_mismatch("tdata pad", 64'(m_axis_tdata[103:100]), 64'd0);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        ready_hold    = 0;
        gaps_enabled  = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        dir_lines     = LINES_RESET;
        for (int k = 0; k < N_LINES; k++)
            dir_tag[k] = '0;
        clear_directory();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_count();
        test_fill_and_evict();
        test_count_extremes();
        test_duplicate_lines();
        test_end_of_run();
        test_random_traffic();
        test_steady_stream();

        drain_lookups();
        repeat (2 * N_LINES) @(posedge i_clk);
        while (pending_lookups.size() != 0) begin
            void'(pending_lookups.pop_front());
            report_mismatch("result never arrived", 64'd0, 64'd0);
        end
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lfac_pkg.sv
rtl/core/lfac_cell.sv
rtl/core/lru_fully_assoc_cache_policy.sv
rtl/core/lfac_chk.sv
bench/tb_top.sv
